### hw/rtl/ett_pkg.sv
// Shared types, constants and codes for the event trigger table.
package ett_pkg;

  localparam int unsigned DefNumEntries = 16;

  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqIncr  = 2'd1;
  localparam logic [1:0] ReqWrite = 2'd2;
  localparam logic [1:0] ReqQuery = 2'd3;

  localparam logic [1:0] KindSpatial  = 2'd0;
  localparam logic [1:0] KindTemporal = 2'd1;
  localparam logic [1:0] KindState    = 2'd2;
  localparam logic [1:0] KindCount    = 2'd3;

  localparam logic [1:0] CfgActive  = 2'd0;
  localparam logic [1:0] CfgActions = 2'd1;
  localparam logic [1:0] CfgCond    = 2'd2;
  localparam logic [1:0] CfgSpatial = 2'd3;

  // Static part of one table entry.
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  kind;
    logic        single_fire;
    logic [15:0] poll_ms;
    logic [31:0] limit;
    logic [31:0] tag;
  } ett_entry_t;

  // Runtime part of one table entry.
  typedef struct packed {
    logic        disabled;
    logic [31:0] elapsed;
    logic [31:0] since_poll;
    logic [31:0] tally;
  } ett_run_t;

  // Settings that steer the shared entry unit.
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] delta_ms;
    logic [15:0] count_delta;
    logic [31:0] tag;
    logic        cond_bit;
    logic        cond_present;
    logic        spatial_present;
  } ett_ctl_t;

  // Unsigned add that sticks at all ones.
  function automatic logic [31:0] sat_add_u32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### hw/rtl/ett_unit.sv
// Shared update unit: computes the new runtime of one entry for a tick or increment.
module ett_unit import ett_pkg::*; (
  input  ett_entry_t entry_i,
  input  ett_run_t   run_i,
  input  ett_ctl_t   ctl_i,
  output ett_run_t   run_o,
  output logic       hit_o
);

  logic [31:0] sp_sum;
  logic        due;
  logic [32:0] tal_sum;
  logic [31:0] el_sum;

  assign sp_sum = sat_add_u32(run_i.since_poll, {16'd0, ctl_i.delta_ms});
  assign due    = (entry_i.poll_ms == 16'd0) || (sp_sum >= {16'd0, entry_i.poll_ms});
  assign el_sum = sat_add_u32(run_i.elapsed, {16'd0, ctl_i.delta_ms});
  assign tal_sum = {run_i.tally[31], run_i.tally} +
                   {{17{ctl_i.count_delta[15]}}, ctl_i.count_delta};

  always_comb begin
    run_o = run_i;
    hit_o = 1'b0;
    if (ctl_i.req == ReqIncr) begin
      // Saturating signed tally update for matching armed count triggers.
      if (!run_i.disabled && entry_i.kind == KindCount && entry_i.tag == ctl_i.tag) begin
        if (tal_sum[32] != tal_sum[31]) begin
          run_o.tally = tal_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          run_o.tally = tal_sum[31:0];
        end
      end
    end else if (!run_i.disabled) begin
      case (entry_i.kind)
        KindTemporal: begin
          run_o.elapsed = el_sum;
          hit_o = entry_i.limit[31] || (el_sum >= entry_i.limit);
        end
        KindState, KindSpatial: begin
          if ((entry_i.kind == KindState) ? ctl_i.cond_present : ctl_i.spatial_present) begin
            run_o.since_poll = due ? 32'd0 : sp_sum;
            hit_o = due && ctl_i.cond_bit;
          end
        end
        default: begin
          run_o.since_poll = due ? 32'd0 : sp_sum;
          hit_o = due && ($signed(run_i.tally) >= $signed(entry_i.limit));
        end
      endcase
      // Firing either disarms a one-shot or restarts the timers.
      if (hit_o) begin
        if (entry_i.single_fire) begin
          run_o.disabled = 1'b1;
        end else begin
          run_o.elapsed    = 32'd0;
          run_o.since_poll = 32'd0;
        end
      end
    end
  end

endmodule

### hw/rtl/event_trigger_table_unit.sv
// Event trigger table: top level with entry storage and the walk sequencer.
// A tick or increment walks min(active_entries, NUM_ENTRIES) slots, one a cycle unless
// stalled; a fired word is staged until the next hit or the walk end sets last, and a
// further hit stalls the walk until the published word is taken. A write, a tick with no
// actions, or a request with no slots skips the walk; a query walks to its first id match
// or the walk end. Reset clears state, registers, timers and tallies at once.
module event_trigger_table_unit import ett_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = DefNumEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] delta_ms_i,
  input  logic [15:0] count_delta_i,
  input  logic [31:0] tag_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] trigger_id_i,
  input  logic [1:0]  trigger_kind_i,
  input  logic        single_fire_i,
  input  logic [15:0] check_interval_ms_i,
  input  logic [31:0] limit_value_i,
  input  logic [15:0] condition_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fired_o,
  output logic [3:0]  fired_index_o,
  output logic [31:0] fired_id_o,
  output logic [1:0]  fired_kind_o,
  output logic        query_found_o,
  output logic        query_has_fired_o,
  output logic        query_is_active_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(NUM_ENTRIES + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  ett_entry_t entry_q [NUM_ENTRIES];
  ett_run_t   run_q   [NUM_ENTRIES];

  logic [4:0] active_q;
  logic       actions_q, cond_q, spat_q;

  logic [1:0]  state_q, state_d;
  logic [CntW-1:0] pos_q, pos_d, len;
  logic [1:0]  req_q;
  logic [15:0] delta_q, cdelta_q, cond_bits_q;
  logic [31:0] tag_q, id_q;

  // Output holding register; a staged fired word gets last once the walk decides it.
  logic        ov_q, pend_q;
  logic        o_fired_q, o_found_q, o_hf_q, o_act_q, o_last_q;
  logic [3:0]  o_idx_q;
  logic [31:0] o_id_q;
  logic [1:0]  o_kind_q;

  logic [IdxW-1:0] cur;
  ett_ctl_t ctl;
  ett_run_t run_new;
  logic     hit;
  logic     at_end;
  logic     stall;

  assign len = (32'(active_q) > NUM_ENTRIES) ? CntW'(NUM_ENTRIES) : CntW'(active_q);
  assign cur = pos_q[IdxW-1:0];
  assign at_end = (pos_q + 1'b1) >= len;
  // A hit can only be staged when neither a staged nor a published word is held.
  assign stall = hit && (req_q == ReqTick) && (pend_q || ov_q);

  always_comb begin
    ctl.req = req_q;
    ctl.delta_ms = delta_q;
    ctl.count_delta = cdelta_q;
    ctl.tag = tag_q;
    ctl.cond_bit = (32'(pos_q) < 32'd16) ? cond_bits_q[4'(pos_q)] : 1'b0;
    ctl.cond_present = cond_q;
    ctl.spatial_present = spat_q;
  end

  ett_unit u_unit (
    .entry_i(entry_q[cur]),
    .run_i  (run_q[cur]),
    .ctl_i  (ctl),
    .run_o  (run_new),
    .hit_o  (hit)
  );

  assign in_ready_o  = (state_q == StIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign fired_o = o_fired_q;
  assign fired_index_o = o_idx_q;
  assign fired_id_o = o_id_q;
  assign fired_kind_o = o_kind_q;
  assign query_found_o = o_found_q;
  assign query_has_fired_o = o_hf_q;
  assign query_is_active_o = o_act_q;
  assign last_o = o_last_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      actions_q <= 1'b0;
      cond_q <= 1'b0;
      spat_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgActive:  active_q <= cfg_data_i;
        CfgActions: actions_q <= cfg_data_i[0];
        CfgCond:    cond_q <= cfg_data_i[0];
        CfgSpatial: spat_q <= cfg_data_i[0];
        default:    active_q <= active_q;
      endcase
    end
  end

  // Static entry fields are written only by entry writes.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && req_type_i == ReqWrite &&
        32'(entry_index_i) < NUM_ENTRIES) begin
      entry_q[IdxW'(entry_index_i)] <= '{id: trigger_id_i, kind: trigger_kind_i,
        single_fire: single_fire_i, poll_ms: check_interval_ms_i, limit: limit_value_i,
        tag: tag_i};
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    case (state_q)
      StIdle: begin
        pos_d = '0;
        if (in_valid_i && in_ready_o) begin
          if (req_type_i == ReqWrite || len == '0 ||
              (req_type_i == ReqTick && !actions_q)) begin
            state_d = (req_type_i == ReqQuery) ? StOut : StIdle;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (req_q == ReqQuery) begin
          if (entry_q[cur].id == id_q || at_end) state_d = StOut;
          else pos_d = pos_q + 1'b1;
        end else if (!stall) begin
          if (at_end) state_d = StOut;
          else pos_d = pos_q + 1'b1;
        end
      end
      StOut: begin
        if (!ov_q) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer, runtime state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q <= '0;
      ov_q <= 1'b0;
      pend_q <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) run_q[i] <= '0;
      o_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (state_q == StIdle && in_valid_i && in_ready_o) begin
        req_q <= req_type_i;
        delta_q <= delta_ms_i;
        cdelta_q <= count_delta_i;
        tag_q <= tag_i;
        id_q <= trigger_id_i;
        cond_bits_q <= condition_bits_i;
        pend_q <= 1'b0;
        if (req_type_i == ReqWrite && 32'(entry_index_i) < NUM_ENTRIES) begin
          run_q[IdxW'(entry_index_i)] <= '0;
        end
        if (req_type_i == ReqQuery) begin
          o_found_q <= 1'b0; o_hf_q <= 1'b0; o_act_q <= 1'b0;
        end
      end
      if (state_q == StWalk) begin
        if (req_q == ReqQuery) begin
          if (entry_q[cur].id == id_q) begin
            o_found_q <= 1'b1;
            o_hf_q <= entry_q[cur].single_fire && run_q[cur].disabled;
            o_act_q <= !run_q[cur].disabled;
          end
        end else if (stall) begin
          // A further hit publishes the staged word, which is then not the last.
          if (pend_q && !ov_q) begin
            o_last_q <= 1'b0;
            ov_q <= 1'b1;
            pend_q <= 1'b0;
          end
        end else begin
          run_q[cur] <= run_new;
          if (hit && req_q == ReqTick) begin
            // A fired trigger is staged; last is settled by the next hit or the walk end.
            pend_q <= 1'b1;
            o_fired_q <= 1'b1;
            o_idx_q <= 4'(pos_q);
            o_id_q <= entry_q[cur].id;
            o_kind_q <= entry_q[cur].kind;
            o_found_q <= 1'b0; o_hf_q <= 1'b0; o_act_q <= 1'b0;
            o_last_q <= 1'b0;
          end
        end
      end
      // At the end of the walk the query word or the final staged word goes out.
      if (state_q == StOut && !ov_q) begin
        if (req_q == ReqQuery) begin
          o_fired_q <= 1'b0;
          o_idx_q <= '0;
          o_id_q <= '0;
          o_kind_q <= '0;
          o_last_q <= 1'b1;
          ov_q <= 1'b1;
        end else if (pend_q) begin
          o_last_q <= 1'b1;
          ov_q <= 1'b1;
          pend_q <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/ett_checker.sv
// Port-level checker for the event trigger table, bound to the top level.
module ett_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic fired_o,
  input logic query_found_o,
  input logic query_is_active_o,
  input logic query_has_fired_o,
  input logic last_o
);

  // A result stays until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fired_o))
    else $error("result dropped before taken");

  // No new item is taken while a result waits.
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  // A query result is always the last of its item.
  a_qlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_o |-> last_o)
    else $error("query result not last");

  // Fired results carry no query flags.
  a_fclean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> !query_found_o && !query_is_active_o && !query_has_fired_o)
    else $error("fired result with query flags");

endmodule

bind event_trigger_table_unit ett_checker u_ett_checker (.*);

### bench/event_trigger_table_unit_tb.sv
// Self-checking testbench for the event trigger table unit.
`timescale 1ns / 100ps

module event_trigger_table_unit_tb import ett_pkg::*; ();

  localparam int unsigned NumSlots   = DefNumEntries;
  localparam int unsigned GapMax     = 18;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleWait = 60;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 60;

  // One input word as it is put on the ports.
  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] delta_ms;
    logic [15:0] count_delta;
    logic [31:0] tag;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [1:0]  kind;
    logic        single_fire;
    logic [15:0] poll_ms;
    logic [31:0] limit;
    logic [15:0] cond;
  } trig_req_t;

  // One output word.
  typedef struct packed {
    logic        fired;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [1:0]  kind;
    logic        found;
    logic        has_fired;
    logic        is_active;
    logic        last;
  } trig_result_t;

  // Trigger table predictor and the queue of results it expects.
  class trigger_scoreboard;
    logic [31:0] id_q[NumSlots];
    logic [1:0]  kind_q[NumSlots];
    logic        single_fire_q[NumSlots];
    logic [15:0] poll_q[NumSlots];
    int          limit_q[NumSlots];
    logic [31:0] tag_q[NumSlots];
    logic        disabled_q[NumSlots];
    logic [31:0] elapsed_q[NumSlots];
    logic [31:0] since_q[NumSlots];
    int          tally_q[NumSlots];
    logic [4:0]  active_cnt;
    logic        actions_on, cond_on, spatial_on;
    trig_result_t pending_results[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        disabled_q[i] = 1'b0;
        elapsed_q[i]  = '0;
        since_q[i]    = '0;
        tally_q[i]    = 0;
      end
      active_cnt = '0;
      actions_on = 1'b0;
      cond_on    = 1'b0;
      spatial_on = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
        CfgActive:  active_cnt = val;
        CfgActions: actions_on = val[0];
        CfgCond:    cond_on    = val[0];
        default:    spatial_on = val[0];
      endcase
    endfunction

    function logic [31:0] add_sticky(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Advances the poll timer; true when the slot is checked this tick.
    function bit poll_now(int i, logic [31:0] delta);
      since_q[i] = add_sticky(since_q[i], delta);
      if (poll_q[i] != 0 && since_q[i] < {16'd0, poll_q[i]}) return 0;
      since_q[i] = '0;
      return 1;
    endfunction

    // Updates the table for an accepted word and queues what it must produce.
    function void note_input(trig_req_t r);
      int unsigned walk;
      int first_hit;
      bit hit;
      longint sum;
      trig_result_t res;
      walk = (active_cnt < NumSlots) ? active_cnt : NumSlots;
      first_hit = -1;
      case (r.req)
        ReqTick: begin
          if (actions_on) begin
            for (int i = 0; i < walk; i++) begin
              if (disabled_q[i]) continue;
              hit = 0;
              case (kind_q[i])
                KindTemporal: begin
                  elapsed_q[i] = add_sticky(elapsed_q[i], {16'd0, r.delta_ms});
                  hit = limit_q[i] < 0 || elapsed_q[i] >= limit_q[i][31:0];
                end
                KindState: if (cond_on) hit = poll_now(i, {16'd0, r.delta_ms}) && r.cond[i];
                KindSpatial: if (spatial_on) hit = poll_now(i, {16'd0, r.delta_ms}) && r.cond[i];
                default: hit = poll_now(i, {16'd0, r.delta_ms}) && tally_q[i] >= limit_q[i];
              endcase
              if (hit) begin
                res = '0;
                res.fired = 1'b1;
                res.slot  = i[3:0];
                res.id    = id_q[i];
                res.kind  = kind_q[i];
                pending_results.insert(pending_results.size(), res);
                first_hit = 1;
                if (single_fire_q[i]) begin
                  disabled_q[i] = 1'b1;
                end else begin
                  elapsed_q[i] = '0;
                  since_q[i]   = '0;
                end
              end
            end
            if (first_hit > 0) pending_results[$].last = 1'b1;
          end
        end
        ReqIncr: begin
          for (int i = 0; i < walk; i++) begin
            if (kind_q[i] == KindCount && !disabled_q[i] && tag_q[i] == r.tag) begin
              sum = longint'(tally_q[i]) + longint'($signed(r.count_delta));
              if (sum > 64'sd2147483647) tally_q[i] = 32'h7FFF_FFFF;
              else if (sum < -64'sd2147483648) tally_q[i] = 32'h8000_0000;
              else tally_q[i] = int'(sum);
            end
          end
        end
        ReqWrite: begin
          id_q[r.slot]          = r.id;
          kind_q[r.slot]        = r.kind;
          single_fire_q[r.slot] = r.single_fire;
          poll_q[r.slot]        = r.poll_ms;
          limit_q[r.slot]       = r.limit;
          tag_q[r.slot]         = r.tag;
          disabled_q[r.slot]    = 1'b0;
          elapsed_q[r.slot]     = '0;
          since_q[r.slot]       = '0;
          tally_q[r.slot]       = 0;
        end
        default: begin
          res = '0;
          res.last = 1'b1;
          for (int i = 0; i < walk; i++) begin
            if (id_q[i] == r.id) begin
              res.found     = 1'b1;
              res.has_fired = single_fire_q[i] && disabled_q[i];
              res.is_active = !disabled_q[i];
              break;
            end
          end
          pending_results.insert(pending_results.size(), res);
        end
      endcase
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endfunction

    // Compares one accepted word with the oldest expectation.
    function void check_result(trig_result_t got);
      trig_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected word", got.id, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.fired !== want.fired) report("fired", got.fired, want.fired);
      if (got.slot !== want.slot) report("fired_index", got.slot, want.slot);
      if (got.id !== want.id) report("fired_id", got.id, want.id);
      if (got.kind !== want.kind) report("fired_kind", got.kind, want.kind);
      if (got.found !== want.found) report("query_found", got.found, want.found);
      if (got.has_fired !== want.has_fired)
        report("query_has_fired", got.has_fired, want.has_fired);
      if (got.is_active !== want.is_active)
        report("query_is_active", got.is_active, want.is_active);
      if (got.last !== want.last) report("last", got.last, want.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  trig_req_t   req_word = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  trig_result_t out_word;

  trigger_scoreboard sb = new();
  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;
  logic [31:0] tag_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0F0F};

  event_trigger_table_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_word.req),
    .delta_ms_i          (req_word.delta_ms),
    .count_delta_i       (req_word.count_delta),
    .tag_i               (req_word.tag),
    .entry_index_i       (req_word.slot),
    .trigger_id_i        (req_word.id),
    .trigger_kind_i      (req_word.kind),
    .single_fire_i       (req_word.single_fire),
    .check_interval_ms_i (req_word.poll_ms),
    .limit_value_i       (req_word.limit),
    .condition_bits_i    (req_word.cond),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .fired_o             (out_word.fired),
    .fired_index_o       (out_word.slot),
    .fired_id_o          (out_word.id),
    .fired_kind_o        (out_word.kind),
    .query_found_o       (out_word.found),
    .query_has_fired_o   (out_word.has_fired),
    .query_is_active_o   (out_word.is_active),
    .last_o              (out_word.last)
  );

  always #4 clk_i = ~clk_i;

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_word);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(GapMax, 0) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [4:0] active, logic actions, logic cond, logic spatial);
    write_reg(CfgActive, active);
    write_reg(CfgActions, {4'd0, actions});
    write_reg(CfgCond, {4'd0, cond});
    write_reg(CfgSpatial, {4'd0, spatial});
  endtask

  // Offers one word after an optional gap and waits until it is taken.
  task automatic send_word(trig_req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(GapMax, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_word   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(r);
  endtask

  // Lets every expected word arrive, then lets a silent walk finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  function automatic trig_req_t rand_word();
    trig_req_t r;
    int unsigned pick;
    r = '0;
    r.delta_ms    = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(300, 0));
    r.count_delta = ($urandom_range(7, 0) == 0) ? 16'($urandom) : 16'($urandom_range(20, 0) - 8);
    r.tag  = ($urandom_range(9, 0) == 0) ? $urandom : tag_pool[$urandom_range(3, 0)];
    r.slot = 4'($urandom);
    r.id   = ($urandom_range(7, 0) == 0) ? $urandom : 32'($urandom_range(23, 0)) * 32'h0101_0101;
    r.kind = 2'($urandom);
    r.single_fire = ($urandom_range(3, 0) == 0);
    r.poll_ms  = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(400, 0));
    if ($urandom_range(9, 0) == 0) r.limit = $urandom;
    else if (r.kind == KindCount) r.limit = 32'($urandom_range(40, 0) - 10);
    else r.limit = 32'($urandom_range(1500, 0));
    r.cond = 16'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      r.req = ReqWrite;
    end else if (pick < 55) begin
      r.req = ReqTick;
    end else if (pick < 82) begin
      r.req = ReqIncr;
      if ($urandom_range(4, 0) != 0) r.tag = sb.tag_q[$urandom_range(NumSlots - 1, 0)];
    end else begin
      r.req = ReqQuery;
      if ($urandom_range(4, 0) != 0) r.id = sb.id_q[$urandom_range(NumSlots - 1, 0)];
    end
    return r;
  endfunction

  initial begin
    trig_req_t r;
    logic [4:0] phase_active[7] = '{5'd16, 5'd31, 5'd5, 5'd16, 5'd1, 5'd0, 5'd16};
    logic [2:0] phase_flags[7]  = '{3'b111, 3'b101, 3'b110, 3'b011, 3'b111, 3'b111, 3'b111};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(5'd0, 1'b0, 1'b0, 1'b0);

    // Fill every slot once, covering every kind and the field extremes.
    for (int i = 0; i < NumSlots; i++) begin
      r = '0;
      r.req         = ReqWrite;
      r.slot        = i[3:0];
      r.id          = (i == 15) ? 32'hFFFF_FFFF : 32'(i) * 32'h0101_0101;
      r.kind        = i[1:0];
      r.single_fire = i[2];
      r.poll_ms     = (i == 3) ? 16'hFFFF : ((i % 3 == 0) ? 16'd0 : 16'd50);
      r.tag         = tag_pool[i % 4];
      case (i)
        1:       r.limit = 32'hFFFF_FFFB;
        5:       r.limit = 32'h7FFF_FFFF;
        7:       r.limit = 32'h8000_0000;
        11:      r.limit = 32'd5;
        default: r.limit = 32'd100;
      endcase
      send_word(r);
    end
    r = '0;
    r.req = ReqTick;
    send_word(r);
    drain();

    // Directed ticks, increments and queries with everything enabled.
    set_regs(5'd16, 1'b1, 1'b1, 1'b1);
    r = '0;
    r.req = ReqIncr; r.tag = tag_pool[3]; r.count_delta = 16'h7FFF; send_word(r);
    r.count_delta = 16'h8000; r.tag = tag_pool[3]; send_word(r);
    r.count_delta = 16'd9; send_word(r);
    r = '0;
    r.req = ReqTick; r.delta_ms = 16'hFFFF; r.cond = 16'hFFFF; send_word(r);
    r.delta_ms = 16'd0; r.cond = 16'h0000; send_word(r);
    r.delta_ms = 16'd60; r.cond = 16'hAAAA; send_word(r);
    r.delta_ms = 16'd60; r.cond = 16'h5555; send_word(r);
    r = '0;
    r.req = ReqQuery; r.id = 32'hFFFF_FFFF; send_word(r);
    r.id = 32'h0404_0404; send_word(r);
    r.id = 32'hDEAD_BEEF; send_word(r);
    drain();

    // Random phases over several register settings.
    for (int p = 0; p < 7; p++) begin
      set_regs(phase_active[p], phase_flags[p][2], phase_flags[p][1], phase_flags[p][0]);
      idle_on = (p % 2 == 1);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == 10) hold_req = 1'b1;
        if (p == 4 && n == 30) idle_on = 1'b0;
        send_word(rand_word());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
